[hdl/bdch_pkg.sv]
package bdch_pkg;

  localparam int unsigned CountW = 8;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned CodeW  = 3;
  localparam int unsigned ModeW  = 2;

  // register indexes on the write port
  localparam logic [2:0] RegClickDetect    = 3'd0;
  localparam logic [2:0] RegIntegratorLim  = 3'd1;
  localparam logic [2:0] RegHoldDelay      = 3'd2;
  localparam logic [2:0] RegClickDelay     = 3'd3;
  localparam logic [2:0] RegRepeatDelay    = 3'd4;

  // event codes
  localparam logic [CodeW-1:0] EvPress       = 3'd0;
  localparam logic [CodeW-1:0] EvRelease     = 3'd1;
  localparam logic [CodeW-1:0] EvHold        = 3'd2;
  localparam logic [CodeW-1:0] EvClick       = 3'd3;
  localparam logic [CodeW-1:0] EvHoldRelease = 3'd4;
  localparam logic [CodeW-1:0] EvRepeat      = 3'd5;

  localparam logic [CountW-1:0] CountMax = 8'hFF;

  typedef struct packed {
    logic             click_detect;
    logic [TimeW-1:0] hold_delay_us;
    logic [TimeW-1:0] click_delay_us;
    logic [TimeW-1:0] repeat_delay_us;
  } timing_cfg_t;

  typedef struct packed {
    logic              fire;
    logic [CodeW-1:0]  code;
    logic [CountW-1:0] count;
  } event_t;

endpackage

[hdl/bdch_integrator.sv]
module bdch_integrator (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic       pin_level,
  input  logic [7:0] limit,
  output logic       debounced_next
);

  logic [7:0] integrator;
  logic [7:0] integrator_next;
  logic       debounced;
  logic [7:0] moved;

  always_comb begin
    moved = integrator;
    if (pin_level) begin
      if (integrator != 8'd0) moved = integrator - 8'd1;
    end else if (integrator < limit) begin
      moved = integrator + 8'd1;
    end
    integrator_next = moved;
    debounced_next  = debounced;
    if (moved == 8'd0) begin
      debounced_next = 1'b0;
    end else if (moved >= limit) begin
      // also clamps when the limit was lowered below the count
      integrator_next = limit;
      debounced_next  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integrator <= '0;
      debounced  <= 1'b0;
    end else if (step) begin
      integrator <= integrator_next;
      debounced  <= debounced_next;
    end
  end

endmodule

[hdl/bdch_fsm.sv]
module bdch_fsm (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      step,
  input  logic                      debounced,
  input  logic [bdch_pkg::TimeW-1:0] now_us,
  input  bdch_pkg::timing_cfg_t     cfg,
  output bdch_pkg::event_t          ev
);

  localparam logic [bdch_pkg::ModeW-1:0] ModeIdle     = 2'd0;
  localparam logic [bdch_pkg::ModeW-1:0] ModePressed  = 2'd1;
  localparam logic [bdch_pkg::ModeW-1:0] ModeReleased = 2'd2;
  localparam logic [bdch_pkg::ModeW-1:0] ModeHold     = 2'd3;

  logic [bdch_pkg::ModeW-1:0]  mode, mode_next;
  logic [bdch_pkg::CountW-1:0] clicks, clicks_next;
  logic [bdch_pkg::TimeW-1:0]  press_stamp, press_stamp_next;
  logic [bdch_pkg::TimeW-1:0]  release_stamp, release_stamp_next;
  logic [bdch_pkg::TimeW-1:0]  repeat_stamp, repeat_stamp_next;
  logic [bdch_pkg::TimeW-1:0]  since_press, since_release, since_repeat;

  // wrapping differences
  assign since_press   = now_us - press_stamp;
  assign since_release = now_us - release_stamp;
  assign since_repeat  = now_us - repeat_stamp;

  always_comb begin
    mode_next          = mode;
    clicks_next        = clicks;
    press_stamp_next   = press_stamp;
    release_stamp_next = release_stamp;
    repeat_stamp_next  = repeat_stamp;
    ev                 = '0;
    unique case (mode)
      ModeIdle: begin
        if (debounced) begin
          press_stamp_next = now_us;
          clicks_next      = '0;
          mode_next        = ModePressed;
          if (!cfg.click_detect) begin
            ev.fire = 1'b1;
            ev.code = bdch_pkg::EvPress;
          end
        end
      end
      ModePressed: begin
        if (!debounced) begin
          if (cfg.click_detect) begin
            release_stamp_next = now_us;
            mode_next          = ModeReleased;
          end else begin
            ev.fire     = 1'b1;
            ev.code     = bdch_pkg::EvRelease;
            ev.count    = clicks;
            clicks_next = '0;
            mode_next   = ModeIdle;
          end
        end else if (cfg.click_detect && since_press >= cfg.hold_delay_us) begin
          ev.fire           = 1'b1;
          ev.code           = bdch_pkg::EvHold;
          ev.count          = clicks;
          repeat_stamp_next = now_us;
          mode_next         = ModeHold;
        end
      end
      ModeReleased: begin
        if (debounced) begin
          press_stamp_next = now_us;
          if (clicks != bdch_pkg::CountMax) clicks_next = clicks + 8'd1;
          mode_next = ModePressed;
        end else if (since_release >= cfg.click_delay_us) begin
          ev.fire     = 1'b1;
          ev.code     = bdch_pkg::EvClick;
          ev.count    = clicks;
          clicks_next = '0;
          mode_next   = ModeIdle;
        end
      end
      ModeHold: begin
        if (!debounced) begin
          ev.fire     = 1'b1;
          ev.code     = bdch_pkg::EvHoldRelease;
          ev.count    = clicks;
          clicks_next = '0;
          mode_next   = ModeIdle;
        end else if (since_repeat >= cfg.repeat_delay_us) begin
          ev.fire           = 1'b1;
          ev.code           = bdch_pkg::EvRepeat;
          ev.count          = clicks;
          repeat_stamp_next = now_us;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= ModeIdle;
      clicks        <= '0;
      press_stamp   <= '0;
      release_stamp <= '0;
      repeat_stamp  <= '0;
    end else if (step) begin
      mode          <= mode_next;
      clicks        <= clicks_next;
      press_stamp   <= press_stamp_next;
      release_stamp <= release_stamp_next;
      repeat_stamp  <= repeat_stamp_next;
    end
  end

endmodule

[hdl/button_debounce_click_hold_unit.sv]
// Button debouncer with click, hold and repeat events. Each request on the
// slave stream is one sample of the active-low pin with a microsecond
// timestamp, and produces exactly one result on the master stream: the
// debounced level plus at most one event (press/release, or with click
// detection on: hold, click with extra-press count, repeat, hold-release).
// One sample is taken every cycle while s_tready is high; a request passes
// the input register, then the result register, the integrator and state
// machine updating once between them. A stalled result holds the input
// register; s_tready drops once that is full too. The user writes registers
// via wr_en/wr_index/wr_data only while the stream is idle (not enforced).
module button_debounce_click_hold_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // pin_level[0], now_us[32:1], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // is_pressed[0], event_valid[1],
                                 // event_code[4:2], click_count[12:5], pad
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [31:0] wr_data
);

  bdch_pkg::timing_cfg_t cfg;
  logic [7:0]            integrator_limit;

  logic                        in_valid;
  logic                        in_pin;
  logic [bdch_pkg::TimeW-1:0]  in_now;
  logic                        advance;
  logic                        debounced_next;
  bdch_pkg::event_t            ev;
  logic [12:0]                 result;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.click_detect    <= 1'b0;
      integrator_limit    <= 8'd3;
      cfg.hold_delay_us   <= 32'd500000;
      cfg.click_delay_us  <= 32'd250000;
      cfg.repeat_delay_us <= 32'd100000;
    end else if (wr_en) begin
      unique case (wr_index)
        bdch_pkg::RegClickDetect:   cfg.click_detect    <= wr_data[0];
        bdch_pkg::RegIntegratorLim: integrator_limit    <= wr_data[7:0];
        bdch_pkg::RegHoldDelay:     cfg.hold_delay_us   <= wr_data;
        bdch_pkg::RegClickDelay:    cfg.click_delay_us  <= wr_data;
        bdch_pkg::RegRepeatDelay:   cfg.repeat_delay_us <= wr_data;
        default: ;
      endcase
    end
  end

  // input stage moves into the result register when that is free or draining
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !rst && (!in_valid || advance);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_pin <= s_tdata[0];
      in_now <= s_tdata[32:1];
    end
  end

  bdch_integrator u_integrator (
    .clk            (clk),
    .rst            (rst),
    .step           (advance),
    .pin_level      (in_pin),
    .limit          (integrator_limit),
    .debounced_next (debounced_next)
  );

  bdch_fsm u_fsm (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .debounced (debounced_next),
    .now_us    (in_now),
    .cfg       (cfg),
    .ev        (ev)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= {ev.count, ev.code, ev.fire, debounced_next};
    end
  end

  assign m_tdata = {3'b000, result};

endmodule

[test/button_debounce_click_hold_unit_tb.sv]
`timescale 1ns / 1ps

module button_debounce_click_hold_unit_tb;

  localparam int unsigned CycleLimit = 400000;

  typedef enum logic [bdch_pkg::ModeW-1:0] {
    BtnIdle, BtnPressed, BtnReleased, BtnHold
  } btn_mode_t;

  typedef struct packed {
    logic                        is_pressed;
    logic                        event_valid;
    logic [bdch_pkg::CodeW-1:0]  code;
    logic [bdch_pkg::CountW-1:0] count;
  } sample_result_t;

  typedef enum logic {RowSample, RowWrite} row_kind_t;

  typedef struct {
    row_kind_t      kind;
    logic           pin;
    logic [31:0]    value;
    logic [2:0]     index;
    bit             typed;
    sample_result_t want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // pin_level[0], now_us[32:1], pad
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // is_pressed[0], event_valid[1], event_code[4:2],
                               // click_count[12:5], pad
  logic        wr_en = 1'b0;
  logic [2:0]  wr_index = '0;
  logic [31:0] wr_data = '0;

  button_debounce_click_hold_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the block's registers and debounce state
  logic                       cfg_click;
  logic [7:0]                 cfg_limit;
  logic [bdch_pkg::TimeW-1:0] cfg_hold;
  logic [bdch_pkg::TimeW-1:0] cfg_click_delay;
  logic [bdch_pkg::TimeW-1:0] cfg_repeat;
  logic [7:0]                 integ_q;
  logic                       pressed_q;
  btn_mode_t                  mode_q;
  logic [7:0]                 clicks_q;
  logic [bdch_pkg::TimeW-1:0] press_at;
  logic [bdch_pkg::TimeW-1:0] release_at;
  logic [bdch_pkg::TimeW-1:0] repeat_at;

  sample_result_t expected_results[$];
  sample_result_t predicted;
  sample_result_t seen;
  sample_result_t want;
  logic           cur_typed = 1'b0;
  sample_result_t cur_want = '0;

  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned samples_sent = 0;
  int unsigned burst_left = 0;
  int unsigned cycles = 0;
  logic [bdch_pkg::TimeW-1:0] stamp_us = '0;
  stim_row_t stim_table[$];

  task automatic clear_state();
    cfg_click = 1'b0;
    cfg_limit = 8'd3;
    cfg_hold = 32'd500000;
    cfg_click_delay = 32'd250000;
    cfg_repeat = 32'd100000;
    integ_q = '0;
    pressed_q = 1'b0;
    mode_q = BtnIdle;
    clicks_q = '0;
    press_at = '0;
    release_at = '0;
    repeat_at = '0;
  endtask

  task automatic predict_sample(input logic pin, input logic [bdch_pkg::TimeW-1:0] now,
                                output sample_result_t r);
    r = '0;
    if (pin) begin
      if (integ_q != 0) integ_q = integ_q - 1'b1;
    end else if (integ_q < cfg_limit) begin
      integ_q = integ_q + 1'b1;
    end
    if (integ_q == 0) begin
      pressed_q = 1'b0;
    end else if (integ_q >= cfg_limit) begin
      integ_q = cfg_limit;
      pressed_q = 1'b1;
    end

    case (mode_q)
      BtnIdle: begin
        if (pressed_q) begin
          press_at = now;
          clicks_q = '0;
          if (!cfg_click) begin
            r.event_valid = 1'b1; r.code = bdch_pkg::EvPress; r.count = clicks_q;
          end
          mode_q = BtnPressed;
        end
      end
      BtnPressed: begin
        if (!pressed_q) begin
          if (cfg_click) begin
            release_at = now;
            mode_q = BtnReleased;
          end else begin
            r.event_valid = 1'b1; r.code = bdch_pkg::EvRelease; r.count = clicks_q;
            clicks_q = '0;
            mode_q = BtnIdle;
          end
        end else if (cfg_click && bdch_pkg::TimeW'(now - press_at) >= cfg_hold) begin
          r.event_valid = 1'b1; r.code = bdch_pkg::EvHold; r.count = clicks_q;
          repeat_at = now;
          mode_q = BtnHold;
        end
      end
      BtnReleased: begin
        if (pressed_q) begin
          press_at = now;
          if (clicks_q != bdch_pkg::CountMax) clicks_q = clicks_q + 1'b1;
          mode_q = BtnPressed;
        end else if (bdch_pkg::TimeW'(now - release_at) >= cfg_click_delay) begin
          r.event_valid = 1'b1; r.code = bdch_pkg::EvClick; r.count = clicks_q;
          clicks_q = '0;
          mode_q = BtnIdle;
        end
      end
      default: begin
        if (!pressed_q) begin
          r.event_valid = 1'b1; r.code = bdch_pkg::EvHoldRelease; r.count = clicks_q;
          clicks_q = '0;
          mode_q = BtnIdle;
        end else if (bdch_pkg::TimeW'(now - repeat_at) >= cfg_repeat) begin
          r.event_valid = 1'b1; r.code = bdch_pkg::EvRepeat; r.count = clicks_q;
          repeat_at = now;
        end
      end
    endcase
    r.is_pressed = pressed_q;
  endtask

  task automatic report_mismatch(input string what, input int unsigned want_v,
                                 input int unsigned got_v);
    mismatches++;
    $display("[%0t] result %0d %s: expected %0d, got %0d",
             $time, results_seen, what, want_v, got_v);
  endtask

  // register writes, accepted requests and results, all seen at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      clear_state();
    end else begin
      if (wr_en) begin
        case (wr_index)
          bdch_pkg::RegClickDetect:   cfg_click = wr_data[0];
          bdch_pkg::RegIntegratorLim: cfg_limit = wr_data[7:0];
          bdch_pkg::RegHoldDelay:     cfg_hold = wr_data;
          bdch_pkg::RegClickDelay:    cfg_click_delay = wr_data;
          bdch_pkg::RegRepeatDelay:   cfg_repeat = wr_data;
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        seen.is_pressed = m_tdata[0];
        seen.event_valid = m_tdata[1];
        seen.code = m_tdata[4:2];
        seen.count = m_tdata[12:5];
        if (expected_results.size() == 0) begin
          report_mismatch("with nothing pending, data", 0, m_tdata);
        end else begin
          want = expected_results.pop_front();
          if (seen.is_pressed !== want.is_pressed)
            report_mismatch("is_pressed", want.is_pressed, seen.is_pressed);
          if (seen.event_valid !== want.event_valid)
            report_mismatch("event_valid", want.event_valid, seen.event_valid);
          if (seen.code !== want.code)
            report_mismatch("event_code", want.code, seen.code);
          if (seen.count !== want.count)
            report_mismatch("click_count", want.count, seen.count);
        end
        results_seen++;
      end
      if (s_tvalid && s_tready) begin
        predict_sample(s_tdata[0], s_tdata[32:1], predicted);
        expected_results.push_back(cur_typed ? cur_want : predicted);
      end
    end
  end

  // receiver: spans of always-ready, random stalls, or a rotating pattern
  int unsigned stall_span = 0;
  int unsigned stall_style = 0;
  logic [7:0]  stall_word = 8'hFF;

  always @(negedge clk) begin
    if (stall_span == 0) begin
      stall_span = $urandom_range(8, 80);
      stall_style = $urandom_range(0, 2);
      stall_word = 8'($urandom_range(1, 255));
    end
    stall_span--;
    case (stall_style)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      default: begin
        m_tready <= stall_word[0];
        stall_word = {stall_word[0], stall_word[7:1]};
      end
    endcase
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("[button_debounce_click_hold_unit] ERROR");
      $finish;
    end
  end

  task automatic send_sample(input logic pin, input logic [bdch_pkg::TimeW-1:0] now,
                             input logic typed, input sample_result_t expect_r);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= {7'd0, now, pin};
    cur_typed <= typed;
    cur_want <= expect_r;
    do @(posedge clk); while (!s_tready);
    samples_sent++;
  endtask

  // mostly small time steps, now and then a jump that may wrap the clock
  task automatic send_tick(input logic pin);
    if ($urandom_range(0, 49) == 0) stamp_us = stamp_us + $urandom;
    else stamp_us = stamp_us + $urandom_range(0, 9);
    send_sample(pin, stamp_us, 1'b0, '0);
  endtask

  task automatic drain_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(negedge clk);
    wr_en <= 1'b0;
  endtask

  function automatic logic [31:0] pick_delay(input int unsigned hi);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom_range(0, hi);
  endfunction

  // bouncy press, hold for a while, bouncy release, rest
  task automatic press_cycle();
    int unsigned n;
    n = $urandom_range(0, 3);
    repeat (n) send_tick($urandom_range(0, 1));
    n = cfg_limit + $urandom_range(0, 30);
    repeat (n) send_tick(1'b0);
    n = $urandom_range(0, 3);
    repeat (n) send_tick($urandom_range(0, 1));
    n = cfg_limit + ($urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 25));
    repeat (n) send_tick(1'b1);
  endtask

  task automatic add_row(input row_kind_t kind, input logic pin, input logic [31:0] value,
                         input logic [2:0] idx, input logic typed, input sample_result_t w);
    stim_row_t row;
    row.kind = kind;
    row.pin = pin;
    row.value = value;
    row.index = idx;
    row.typed = typed;
    row.want = w;
    stim_table.push_back(row);
  endtask

  task automatic add_checked(input logic pin, input logic [31:0] now, input logic p,
                             input logic v, input logic [bdch_pkg::CodeW-1:0] code,
                             input logic [bdch_pkg::CountW-1:0] cnt);
    add_row(RowSample, pin, now, '0, 1'b1, '{p, v, code, cnt});
  endtask

  initial begin
    int unsigned phase_end;

    // reset settings: plain press/release, limit 3
    add_checked(1'b1, 32'd0, 1'b0, 1'b0, '0, '0);
    add_checked(1'b0, 32'd1, 1'b0, 1'b0, '0, '0);
    add_checked(1'b0, 32'd2, 1'b0, 1'b0, '0, '0);
    add_checked(1'b0, 32'd3, 1'b1, 1'b1, bdch_pkg::EvPress, '0);
    add_checked(1'b0, 32'hFFFF_FFFF, 1'b1, 1'b0, '0, '0);
    add_checked(1'b1, 32'd4, 1'b1, 1'b0, '0, '0);
    add_checked(1'b1, 32'd5, 1'b1, 1'b0, '0, '0);
    add_checked(1'b1, 32'd6, 1'b0, 1'b1, bdch_pkg::EvRelease, '0);
    // click detection with short delays
    add_row(RowWrite, 1'b0, 32'd1, bdch_pkg::RegClickDetect, 1'b0, '0);
    add_row(RowWrite, 1'b0, 32'd1, bdch_pkg::RegIntegratorLim, 1'b0, '0);
    add_row(RowWrite, 1'b0, 32'd100, bdch_pkg::RegHoldDelay, 1'b0, '0);
    add_row(RowWrite, 1'b0, 32'd50, bdch_pkg::RegClickDelay, 1'b0, '0);
    add_row(RowWrite, 1'b0, 32'd20, bdch_pkg::RegRepeatDelay, 1'b0, '0);
    add_checked(1'b0, 32'd1000, 1'b1, 1'b0, '0, '0);
    add_checked(1'b1, 32'd1010, 1'b0, 1'b0, '0, '0);
    add_checked(1'b0, 32'd1020, 1'b1, 1'b0, '0, '0);
    add_checked(1'b1, 32'd1030, 1'b0, 1'b0, '0, '0);
    add_checked(1'b1, 32'd1080, 1'b0, 1'b1, bdch_pkg::EvClick, 8'd1);
    add_checked(1'b0, 32'd2000, 1'b1, 1'b0, '0, '0);
    add_checked(1'b0, 32'd2100, 1'b1, 1'b1, bdch_pkg::EvHold, '0);
    add_checked(1'b0, 32'd2120, 1'b1, 1'b1, bdch_pkg::EvRepeat, '0);
    add_checked(1'b1, 32'd2121, 1'b0, 1'b1, bdch_pkg::EvHoldRelease, '0);
    // timestamp steps backwards: looks like a very long press
    add_checked(1'b0, 32'd5, 1'b1, 1'b0, '0, '0);
    add_checked(1'b0, 32'd4, 1'b1, 1'b1, bdch_pkg::EvHold, '0);
    add_checked(1'b1, 32'd6, 1'b0, 1'b1, bdch_pkg::EvHoldRelease, '0);
    // widest limit and delays, then limit cut below the integrator, then zero limit
    add_row(RowWrite, 1'b0, 32'd255, bdch_pkg::RegIntegratorLim, 1'b0, '0);
    add_row(RowWrite, 1'b0, 32'hFFFF_FFFF, bdch_pkg::RegHoldDelay, 1'b0, '0);
    add_row(RowWrite, 1'b0, 32'hFFFF_FFFF, bdch_pkg::RegClickDelay, 1'b0, '0);
    add_row(RowWrite, 1'b0, 32'hFFFF_FFFF, bdch_pkg::RegRepeatDelay, 1'b0, '0);
    add_row(RowSample, 1'b0, 32'd7, '0, 1'b0, '0);
    add_row(RowSample, 1'b0, 32'd8, '0, 1'b0, '0);
    add_row(RowSample, 1'b0, 32'd9, '0, 1'b0, '0);
    add_row(RowWrite, 1'b0, 32'd2, bdch_pkg::RegIntegratorLim, 1'b0, '0);
    add_row(RowSample, 1'b0, 32'd10, '0, 1'b0, '0);
    add_row(RowWrite, 1'b0, 32'd0, bdch_pkg::RegIntegratorLim, 1'b0, '0);
    add_row(RowSample, 1'b1, 32'd11, '0, 1'b0, '0);
    add_row(RowSample, 1'b0, 32'd12, '0, 1'b0, '0);
    add_row(RowSample, 1'b1, 32'd13, '0, 1'b0, '0);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (stim_table[i]) begin
      if (stim_table[i].kind == RowWrite) begin
        drain_results();
        write_reg(stim_table[i].index, stim_table[i].value);
      end else begin
        send_sample(stim_table[i].pin, stim_table[i].value, stim_table[i].typed,
                    stim_table[i].want);
      end
    end

    // random phases; settings change while the state machine may sit mid-sequence
    for (int p = 0; p < 8; p++) begin
      drain_results();
      write_reg(bdch_pkg::RegClickDetect, $urandom_range(0, 1));
      write_reg(bdch_pkg::RegIntegratorLim,
                ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : $urandom_range(1, 4));
      write_reg(bdch_pkg::RegHoldDelay, pick_delay(60));
      write_reg(bdch_pkg::RegClickDelay, pick_delay(40));
      write_reg(bdch_pkg::RegRepeatDelay, pick_delay(20));
      stamp_us = $urandom;
      phase_end = samples_sent + 50;
      while (samples_sent < phase_end) begin
        if ($urandom_range(0, 7) == 0) send_tick($urandom_range(0, 1));
        else press_cycle();
      end
    end

    // enough quick presses to saturate the click count, then let the click fire
    drain_results();
    write_reg(bdch_pkg::RegClickDetect, 32'd1);
    write_reg(bdch_pkg::RegIntegratorLim, 32'd1);
    write_reg(bdch_pkg::RegHoldDelay, 32'hFFFF_FFFF);
    write_reg(bdch_pkg::RegClickDelay, 32'hFFFF_FFFF);
    stamp_us = $urandom;
    send_sample(1'b1, stamp_us, 1'b0, '0);
    repeat (260) begin
      stamp_us = stamp_us + 1'b1;
      send_sample(1'b0, stamp_us, 1'b0, '0);
      stamp_us = stamp_us + 1'b1;
      send_sample(1'b1, stamp_us, 1'b0, '0);
    end
    drain_results();
    write_reg(bdch_pkg::RegClickDelay, 32'd0);
    send_sample(1'b1, stamp_us + 1'b1, 1'b1,
                '{1'b0, 1'b1, bdch_pkg::EvClick, bdch_pkg::CountMax});

    drain_results();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("[button_debounce_click_hold_unit] OK");
    end else begin
      $display("[button_debounce_click_hold_unit] ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/bdch_pkg.sv
hdl/bdch_integrator.sv
hdl/bdch_fsm.sv
hdl/button_debounce_click_hold_unit.sv
test/button_debounce_click_hold_unit_tb.sv
